>>> rtl/core/shift_array_list_engine_core_macros.svh
// Assertion macros used by the list engine execution unit.
`ifndef SHIFT_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define SHIFT_ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SALE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SALE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sale_pkg.sv
// Shared types and constants of the list engine.
package sale_pkg;

    // Default number of list entries.
    localparam int DEPTH_DEF = 8;

    // Depth of the command queue between front and back; a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Operation codes.
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_UPDATE  = 3'd2;
    localparam logic [2:0] OP_REVERSE = 3'd3;
    localparam logic [2:0] OP_SEARCH  = 3'd4;
    localparam logic [2:0] OP_DUMP    = 3'd5;

    // A classified command: the slot is the clamped 0-based position.
    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         slot;
        logic signed [31:0] value;
    } t_cmd;

endpackage

>>> rtl/core/shift_array_list_engine_core.sv
// Top level of the shift-array list engine.
//
//  Channel | Handshake                 | Fields
//  --------+---------------------------+-------------------------------------------------
//  input   | i_in_valid / o_in_ready   | i_op, i_position, i_value
//  output  | o_out_valid / i_out_ready | o_entry_value, o_entry_position, o_found, o_last
//
// A transfer reaches the execution unit via the front register and the command queue.
// Insert, delete, update and reverse are applied to the list as the command is taken.
// Search and dump first take the command, then rotate the list once through its head
// entry, registering a dump result on each rotation step and a search result on the last.
// A stalled output holds the rotation in place; the front end keeps taking a transfer
// per cycle while the command queue has room. Reset is synchronous and clears the list.
module shift_array_list_engine_core
    import sale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [3:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_entry_value,
    output logic [3:0]         o_entry_position,
    output logic               o_found,
    output logic               o_last
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    sale_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    sale_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    sale_exec #(.DEPTH(DEPTH)) u_exec (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_valid),
        .o_cmd_ready      (q_ready),
        .i_cmd            (q_cmd),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_entry_value    (o_entry_value),
        .o_entry_position (o_entry_position),
        .o_found          (o_found),
        .o_last           (o_last)
    );

endmodule

>>> rtl/core/sale_front.sv
// Front end: accepts items, drops unknown opcodes and clamps the position.
module sale_front
    import sale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [3:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output t_cmd               o_cmd
);

    logic       r_valid;
    t_cmd       r_cmd;
    logic       op_known;
    logic [3:0] pos_clamped;

    // The stage takes a transfer when it is empty or drains this cycle.
    assign o_in_ready = !r_valid || i_cmd_ready;

    // Decode the opcode; spare codes change nothing and are dropped here.
    always_comb begin
        case (i_op)
            OP_INSERT, OP_DELETE, OP_UPDATE,
            OP_REVERSE, OP_SEARCH, OP_DUMP: op_known = 1'b1;
            default:                       op_known = 1'b0;
        endcase
    end

    // Clamp the 1-based position into 1..DEPTH.
    always_comb begin
        pos_clamped = i_position;
        if (pos_clamped == 4'd0) begin
            pos_clamped = 4'd1;
        end
        if (int'(pos_clamped) > DEPTH) begin
            pos_clamped = 4'(DEPTH);
        end
    end

    // Command register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && op_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd.op    <= i_op;
            r_cmd.slot  <= pos_clamped - 4'd1;
            r_cmd.value <= i_value;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

>>> rtl/core/sale_queue.sv
// Short command queue that decouples the front end from the execution unit.
module sale_queue
    import sale_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

>>> rtl/core/sale_exec.sv
// Execution unit: holds the shift array and carries out one command at a time.
module sale_exec
    import sale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_entry_value,
    output logic [3:0]         o_entry_position,
    output logic               o_found,
    output logic               o_last
);

    `include "shift_array_list_engine_core_macros.svh"

    localparam int IW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_exec_state;

    t_exec_state        r_state, n_state;
    logic signed [31:0] r_entries [DEPTH];
    logic signed [31:0] n_entries [DEPTH];
    logic [IW-1:0]      r_cnt;
    logic               r_is_dump;
    logic signed [31:0] r_key;
    logic               r_hit;
    logic [3:0]         r_hit_pos;
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic [3:0]         r_out_pos;
    logic               r_out_found;
    logic               r_out_last;

    logic               out_free;
    logic               take;
    logic               step;
    logic               scan_end;
    logic               match;
    logic [IW:0]        pos_full;
    logic [3:0]         pos_now;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign step        = (r_state == ST_SCAN) && out_free;
    assign scan_end    = (r_cnt == IW'(DEPTH - 1));
    assign match       = (r_entries[0] == r_key);
    assign pos_full    = {1'b0, r_cnt} + 1'b1;
    assign pos_now     = 4'(pos_full);

    // Next contents of the list: direct edits for a taken command, or a rotate by one place
    // while scanning so that the head entry is always the one examined.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
        end
        if (take) begin
            case (i_cmd.op)
                OP_INSERT: begin
                    for (int i = 1; i < DEPTH; i++) begin
                        if (i > int'(i_cmd.slot)) begin
                            n_entries[i] = r_entries[i-1];
                        end
                    end
                    for (int i = 0; i < DEPTH; i++) begin
                        if (i == int'(i_cmd.slot)) begin
                            n_entries[i] = i_cmd.value;
                        end
                    end
                end
                OP_DELETE: begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (i >= int'(i_cmd.slot)) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_entries[DEPTH-1] = '0;
                end
                OP_UPDATE: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (i == int'(i_cmd.slot)) begin
                            n_entries[i] = i_cmd.value;
                        end
                    end
                end
                OP_REVERSE: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        n_entries[i] = r_entries[DEPTH-1-i];
                    end
                end
                default: begin
                end
            endcase
        end else if (step) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_entries[i] = r_entries[i+1];
            end
            n_entries[DEPTH-1] = r_entries[0];
        end
    end

    // Sequencer: search and dump walk the list once, everything else leaves it idle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take && (i_cmd.op == OP_SEARCH || i_cmd.op == OP_DUMP)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step && scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // List storage, cleared to zero at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= '0;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    // Control state and scan counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end else if (step) begin
                r_cnt <= scan_end ? '0 : r_cnt + 1'b1;
                if (!r_is_dump && match) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // Scan payload: operation kind, search key and first match position.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_is_dump <= (i_cmd.op == OP_DUMP);
            r_key     <= i_cmd.value;
        end
        if (step && !r_hit && match) begin
            r_hit_pos <= pos_now;
        end
    end

    // Output register: a dump emits on every step, a search on its last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && (r_is_dump || scan_end)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (r_is_dump || scan_end)) begin
            r_out_last <= scan_end;
            if (r_is_dump) begin
                r_out_value <= r_entries[0];
                r_out_pos   <= pos_now;
                r_out_found <= 1'b0;
            end else begin
                r_out_value <= r_key;
                r_out_found <= r_hit || match;
                if (r_hit) begin
                    r_out_pos <= r_hit_pos;
                end else if (match) begin
                    r_out_pos <= pos_now;
                end else begin
                    r_out_pos <= 4'd0;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_entry_value    = r_out_value;
    assign o_entry_position = r_out_pos;
    assign o_found          = r_out_found;
    assign o_last           = r_out_last;

    // The scan counter rests at zero between commands.
    `SALE_ASSERT_IMP(a_cnt_idle, i_clk, i_rst_n, r_state == ST_IDLE, r_cnt == '0, "scan counter not at rest")
    // A search hit always closes its command.
    `SALE_ASSERT_IMP(a_found_last, i_clk, i_rst_n, o_out_valid && o_found, o_last, "found without last")
    // The final scan step leaves a last result and an idle sequencer.
    `SALE_ASSERT_NXT(a_scan_close, i_clk, i_rst_n, step && scan_end, (r_state == ST_IDLE) && o_out_valid && o_last, "scan did not close")

endmodule
